### rtl/eia3_pkg.sv
// Shared types, constants and the keystream window function for the 128-EIA3 tag block.
package eia3_pkg;

  localparam int WORD_BITS   = 32;
  localparam int COUNT_W     = 6;
  localparam int CMD_W       = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(WORD_BITS);

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  // One classified request on its way from the front end to the hash engine.
  typedef struct packed {
    cmd_t                 kind;
    logic [WORD_BITS-1:0] data;
    logic [COUNT_W-1:0]   count;
    logic [WORD_BITS-1:0] keystream;
  } entry_t;

  // Keystream window starting at bit offset off of prev:cur; an offset of 32 yields cur.
  function automatic logic [WORD_BITS-1:0] window_at(
    input logic [WORD_BITS-1:0] prev,
    input logic [WORD_BITS-1:0] cur,
    input logic [COUNT_W-1:0]   off
  );
    logic [2*WORD_BITS-1:0] joined;
    joined = {prev, cur} << off;
    return joined[2*WORD_BITS-1:WORD_BITS];
  endfunction

endpackage

### rtl/eia3_front.sv
// Front end: accepts requests, drops unused codes, saturates the count and masks unused bits.
module eia3_front
  import eia3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [WORD_BITS-1:0] in_data_word,
  input  logic [COUNT_W-1:0]   in_bit_count,
  input  logic [WORD_BITS-1:0] in_keystream_word,
  output logic                 fe_valid,
  output entry_t               fe_entry,
  input  logic                 q_full
);

  logic               fe_valid_r, fe_valid_nxt;
  entry_t             fe_entry_r, fe_entry_nxt;
  logic               accept;
  logic               known_cmd;
  logic [COUNT_W-1:0] count_sat;
  logic [WORD_BITS-1:0] keep_mask;

  assign in_stall = fe_valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    case (in_cmd)
      CMD_START, CMD_DATA, CMD_FINISH: known_cmd = 1'b1;
      default:                         known_cmd = 1'b0;
    endcase
  end

  assign count_sat = (in_bit_count > FULL_COUNT) ? FULL_COUNT : in_bit_count;

  // Bits past the count never contribute, so they are cleared here once.
  assign keep_mask = (count_sat == FULL_COUNT) ? {WORD_BITS{1'b1}}
                                               : ~({WORD_BITS{1'b1}} >> count_sat);

  always_comb begin
    fe_valid_nxt = fe_valid_r;
    fe_entry_nxt = fe_entry_r;
    if (fe_valid_r && !q_full) begin
      fe_valid_nxt = 1'b0;
    end
    if (accept) begin
      fe_valid_nxt       = known_cmd;
      fe_entry_nxt.kind      = cmd_t'(in_cmd);
      fe_entry_nxt.data      = in_data_word & keep_mask;
      fe_entry_nxt.count     = count_sat;
      fe_entry_nxt.keystream = in_keystream_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else begin
      fe_valid_r <= fe_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fe_entry_r <= fe_entry_nxt;
  end

  assign fe_valid = fe_valid_r;
  assign fe_entry = fe_entry_r;

endmodule

### rtl/eia3_queue.sv
// Short request queue that decouples the front end from the hash engine.
module eia3_queue
  import eia3_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  input  entry_t push_entry,
  output logic   full,
  output logic   pop_valid,
  output entry_t pop_entry,
  input  logic   pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t            slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign pop_valid = (cnt_r != '0);
  assign pop_entry = slots_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### rtl/eia3_back.sv
// Hash engine: keystream state, tag accumulation and the registered MAC output.
module eia3_back
  import eia3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  entry_t               q_entry,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] out_mac
);

  logic [WORD_BITS-1:0] prev_ks_r, prev_ks_nxt;
  logic [WORD_BITS-1:0] cur_ks_r, cur_ks_nxt;
  logic [WORD_BITS-1:0] tag_r, tag_nxt;
  logic [COUNT_W-1:0]   tail_r, tail_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_mac_r, out_mac_nxt;
  logic [WORD_BITS-1:0] word_hash;
  logic                 is_finish;

  assign is_finish = (q_entry.kind == CMD_FINISH);
  // A finish waits only while an undelivered MAC still sits in the output register.
  assign q_pop = q_valid && (!is_finish || !out_valid_r || !out_stall);

  // Each set message bit selects the window at its own offset; unused bits arrive cleared.
  always_comb begin
    word_hash = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (q_entry.data[WORD_BITS-1-j]) begin
        word_hash = word_hash ^ window_at(cur_ks_r, q_entry.keystream, COUNT_W'(j));
      end
    end
  end

  always_comb begin
    prev_ks_nxt   = prev_ks_r;
    cur_ks_nxt    = cur_ks_r;
    tag_nxt       = tag_r;
    tail_nxt      = tail_r;
    out_mac_nxt   = out_mac_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop) begin
      case (q_entry.kind)
        CMD_START: begin
          prev_ks_nxt = '0;
          cur_ks_nxt  = q_entry.keystream;
          tag_nxt     = '0;
          tail_nxt    = FULL_COUNT;
        end
        CMD_DATA: begin
          prev_ks_nxt = cur_ks_r;
          cur_ks_nxt  = q_entry.keystream;
          tag_nxt     = tag_r ^ word_hash;
          tail_nxt    = q_entry.count;
        end
        CMD_FINISH: begin
          out_valid_nxt = 1'b1;
          out_mac_nxt   = tag_r ^ window_at(prev_ks_r, cur_ks_r, tail_r) ^ q_entry.keystream;
        end
        default: begin
          out_valid_nxt = out_valid_r && out_stall;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ks_r   <= '0;
      cur_ks_r    <= '0;
      tag_r       <= '0;
      tail_r      <= FULL_COUNT;
      out_valid_r <= 1'b0;
    end else begin
      prev_ks_r   <= prev_ks_nxt;
      cur_ks_r    <= cur_ks_nxt;
      tag_r       <= tag_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mac_r <= out_mac_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_mac   = out_mac_r;

endmodule

### rtl/eia3_universal_hash_mac_core.sv
// Top level of the 128-EIA3 integrity tag block.
//
// Input channel (in_valid/in_stall): each request carries in_cmd, in_data_word,
// in_bit_count and in_keystream_word. A start request loads the first keystream
// word and clears the tag, a data request adds 32 message bits (first bit in bit
// 31, fewer only on the last word) with the next keystream word, and a finish
// request brings one more keystream word and produces the MAC. Code three is dropped.
// Output channel (out_valid/out_stall): one out_mac per finish request, in order.
// A request passes a front-end register and a QUEUE_DEPTH-entry queue; the hash
// engine takes one request per cycle, so one is accepted every cycle, unless a
// finish waits on a held MAC. A finish passes the front-end register and a queue
// slot before its MAC is registered. A word's 32 keystream windows sum combinationally.
// When the receiver stalls, the MAC holds in the output register; later data
// requests keep flowing, and a second finish waits in the queue, so in_stall
// rises only once the queue and the front-end register are full.
// Synchronous reset clears the queue, the output valid flag and the keystream and tag state.
module eia3_universal_hash_mac_core
  import eia3_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [WORD_BITS-1:0] in_data_word,
  input  logic [COUNT_W-1:0]   in_bit_count,
  input  logic [WORD_BITS-1:0] in_keystream_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] out_mac
);

  logic   fe_valid;
  entry_t fe_entry;
  logic   q_full;
  logic   q_valid;
  entry_t q_entry;
  logic   q_pop;

  eia3_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_data_word      (in_data_word),
    .in_bit_count      (in_bit_count),
    .in_keystream_word (in_keystream_word),
    .fe_valid          (fe_valid),
    .fe_entry          (fe_entry),
    .q_full            (q_full)
  );

  eia3_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_entry (fe_entry),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .pop        (q_pop)
  );

  eia3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_mac   (out_mac)
  );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the 128-EIA3 tag core: random request streams against a tag predictor.
module tb_top
  import eia3_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_OFF_LEN  = 300;

  typedef enum int {
    PH_STEADY, PH_PRESSURE, PH_SEND_GAPS, PH_RECV_STALLS, PH_BOTH
  } phase_t;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [WORD_BITS-1:0] data;
    logic [COUNT_W-1:0]   count;
    logic [WORD_BITS-1:0] keystream;
  } request_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd = '0;
  logic [WORD_BITS-1:0] in_data_word = '0;
  logic [COUNT_W-1:0]   in_bit_count = '0;
  logic [WORD_BITS-1:0] in_keystream_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_BITS-1:0] out_mac;

  request_t             pending_reqs[$];
  logic [WORD_BITS-1:0] mac_expected[$];

  // Predicted tag state.
  logic [WORD_BITS-1:0] ks_prev = '0;
  logic [WORD_BITS-1:0] ks_cur = '0;
  logic [WORD_BITS-1:0] tag_sum = '0;
  int unsigned          tail_len = WORD_BITS;

  phase_t phase = PH_STEADY;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_cycles = 0;
  int     mismatches = 0;
  int     queued_total = 0;
  int     cycle_count = 0;

  eia3_universal_hash_mac_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_data_word      (in_data_word),
    .in_bit_count      (in_bit_count),
    .in_keystream_word (in_keystream_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mac           (out_mac)
  );

  always #4 clk = ~clk;

  // 32-bit keystream slice starting at bit offset off of prev:cur.
  function automatic logic [WORD_BITS-1:0] ks_window(input logic [WORD_BITS-1:0] prev,
                                                     input logic [WORD_BITS-1:0] cur,
                                                     input int unsigned off);
    if (off == 0) return prev;
    if (off >= WORD_BITS) return cur;
    return (prev << off) | (cur >> (WORD_BITS - off));
  endfunction

  task automatic absorb_request(input request_t req);
    int unsigned cnt;
    cnt = (req.count > WORD_BITS) ? WORD_BITS : req.count;
    case (req.cmd)
      CMD_START: begin
        ks_prev  = '0;
        ks_cur   = req.keystream;
        tag_sum  = '0;
        tail_len = WORD_BITS;
      end
      CMD_DATA: begin
        ks_prev = ks_cur;
        ks_cur  = req.keystream;
        for (int j = 0; j < cnt; j++) begin
          if (req.data[WORD_BITS-1-j]) tag_sum ^= ks_window(ks_prev, ks_cur, j);
        end
        tail_len = cnt;
      end
      CMD_FINISH: begin
        mac_expected.push_back(tag_sum ^ ks_window(ks_prev, ks_cur, tail_len) ^ req.keystream);
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [WORD_BITS-1:0] exp_mac,
                               input logic [WORD_BITS-1:0] got_mac);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %h, got %h", $realtime, what, exp_mac, got_mac);
  endtask

  task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [WORD_BITS-1:0] data,
                          input logic [COUNT_W-1:0] count, input logic [WORD_BITS-1:0] ks);
    request_t req;
    req.cmd       = cmd;
    req.data      = data;
    req.count     = count;
    req.keystream = ks;
    pending_reqs.push_back(req);
    queued_total++;
  endtask

  // A complete start, data, finish sequence; short words mostly at the end.
  task automatic push_message();
    int               nwords;
    logic [COUNT_W-1:0] cnt;
    nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    push_req(CMD_START, $urandom, COUNT_W'($urandom_range(0, 63)), $urandom);
    for (int i = 0; i < nwords; i++) begin
      cnt = FULL_COUNT;
      if (i == nwords - 1 && $urandom_range(0, 1) == 1) cnt = COUNT_W'($urandom_range(1, 31));
      else if ($urandom_range(0, 19) == 0) cnt = COUNT_W'($urandom_range(0, 63));
      push_req(CMD_DATA, $urandom, cnt, $urandom);
    end
    push_req(CMD_FINISH, $urandom, COUNT_W'($urandom_range(0, 63)), $urandom);
  endtask

  task automatic push_traffic(input int target);
    int stop_at;
    stop_at = queued_total + target;
    while (queued_total < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        push_message();
      end else begin
        case ($urandom_range(0, 3))
          0: push_req(CMD_UNUSED, $urandom, COUNT_W'($urandom_range(0, 63)), $urandom);
          1: push_req(CMD_DATA, $urandom, COUNT_W'($urandom_range(0, 63)), $urandom);
          2: push_req(CMD_FINISH, $urandom, COUNT_W'($urandom_range(0, 63)), $urandom);
          default: push_req(CMD_START, $urandom, COUNT_W'($urandom_range(0, 63)), $urandom);
        endcase
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || mac_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic enter_phase(input phase_t next_phase, input int idle_pct, input int stall_pct);
    @(negedge clk);
    phase          = next_phase;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Sender: holds a request until it is taken, then offers the next one or idles.
  always @(posedge clk) begin : request_driver
    request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        absorb_request({in_cmd, in_data_word, in_bit_count, in_keystream_word});
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_valid          <= 1'b1;
          in_cmd            <= nxt.cmd;
          in_data_word      <= nxt.data;
          in_bit_count      <= nxt.count;
          in_keystream_word <= nxt.keystream;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold-off in the pressure phase, random stalls otherwise.
  always @(posedge clk) begin : mac_receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (phase == PH_PRESSURE && hold_cycles < HOLD_OFF_LEN) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : mac_monitor
    logic [WORD_BITS-1:0] exp_mac;
    if (rst_n && out_valid && !out_stall) begin
      if (mac_expected.size() == 0) begin
        note_mismatch("MAC with no finish pending", '0, out_mac);
      end else begin
        exp_mac = mac_expected.pop_front();
        if (out_mac !== exp_mac) note_mismatch("MAC value", exp_mac, out_mac);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    enter_phase(PH_STEADY, 0, 0);
    // Finish and data straight out of reset, then a stray unused code.
    push_req(CMD_FINISH, 32'h0, 6'd32, 32'hA5A5_5A5A);
    push_req(CMD_DATA, 32'hFFFF_FFFF, 6'd32, 32'h1234_5678);
    push_req(CMD_FINISH, 32'h0, 6'd0, 32'h0);
    push_req(CMD_UNUSED, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
    // All-ones and all-zeros words with a one-bit tail.
    push_req(CMD_START, 32'h0, 6'd0, 32'hFFFF_FFFF);
    push_req(CMD_DATA, 32'hFFFF_FFFF, 6'd32, 32'h0);
    push_req(CMD_DATA, 32'h0, 6'd32, 32'hFFFF_FFFF);
    push_req(CMD_DATA, 32'h8000_0001, 6'd1, 32'h8000_0001);
    push_req(CMD_FINISH, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
    // A zero-length word makes the finish window the previous keystream word.
    push_req(CMD_START, 32'h0, 6'd0, 32'hDEAD_BEEF);
    push_req(CMD_DATA, 32'hFFFF_FFFF, 6'd0, 32'hCAFE_F00D);
    push_req(CMD_FINISH, 32'h0, 6'd0, 32'h0F0F_F0F0);
    // Counts above thirty-two saturate.
    push_req(CMD_START, 32'h0, 6'd0, 32'h1357_9BDF);
    push_req(CMD_DATA, 32'hAAAA_5555, 6'd63, 32'h2468_ACE0);
    push_req(CMD_DATA, 32'h0123_4567, 6'd33, 32'hFEDC_BA98);
    push_req(CMD_FINISH, 32'h0, 6'd32, 32'h7777_8888);
    // A short word in the middle, then an unused code inside the message.
    push_req(CMD_START, 32'h0, 6'd0, 32'h89AB_CDEF);
    push_req(CMD_DATA, 32'hF800_0000, 6'd5, 32'h0000_FFFF);
    push_req(CMD_UNUSED, 32'h0, 6'd0, 32'h0);
    push_req(CMD_DATA, 32'h7FFF_FFFE, 6'd31, 32'hFFFF_0000);
    push_req(CMD_FINISH, 32'h0, 6'd32, 32'h5555_AAAA);
    // An empty message and back-to-back finishes.
    push_req(CMD_START, 32'h0, 6'd0, 32'h0000_0001);
    push_req(CMD_FINISH, 32'h0, 6'd0, 32'h8000_0000);
    push_req(CMD_FINISH, 32'h0, 6'd0, 32'h8000_0000);
    push_traffic(450);
    wait_idle();

    // The sender keeps offering while the receiver holds off, so the input stalls.
    enter_phase(PH_PRESSURE, 0, 0);
    push_traffic(100);
    wait_idle();

    enter_phase(PH_SEND_GAPS, 49, 0);
    push_traffic(450);
    wait_idle();

    enter_phase(PH_RECV_STALLS, 0, 49);
    push_traffic(450);
    wait_idle();

    enter_phase(PH_BOTH, 21, 21);
    push_traffic(420);
    wait_idle();

    if (mismatches == 0 && mac_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/eia3_pkg.sv
rtl/eia3_front.sv
rtl/eia3_queue.sv
rtl/eia3_back.sv
rtl/eia3_universal_hash_mac_core.sv
tb/sv/tb_top.sv
